// ----- sv/scre_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the sprite column run encoder.
// No dependencies; every other file refers to this package by scoped names.
package scre_pkg;

	localparam int ADDR_W   = 20;
	localparam int COLOR_W  = 16;
	localparam int HEIGHT_W = 9;
	localparam int START_W  = 8;
	localparam int LENGTH_W = 9;
	localparam int COUNT_W  = 8;
	localparam int INDEX_W  = 2;

	typedef enum logic [INDEX_W-1:0] {
		CFG_BACKGROUND = 2'd0,
		CFG_HEIGHT     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  background;
		logic [HEIGHT_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic                store_valid;
		logic [ADDR_W-1:0]   store_address;
		logic [COLOR_W-1:0]  store_pixel;
		logic                run_done;
		logic [START_W-1:0]  run_start;
		logic [LENGTH_W-1:0] run_length;
		logic [ADDR_W-1:0]   run_address;
		logic                column_done;
		logic [COUNT_W-1:0]  column_run_count;
	} result_t;

endpackage

// ----- sv/sprite_column_run_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the sprite column run encoder: input and result registers around the tracker.
// Depends on scre_pkg, scre_cfg and scre_run_tracker.
//
// Accepts one RGB565 pixel per clock in column order while pixel_stall is low and returns
// exactly one result beat per pixel, from the input register through the result
// register, with the run and column state updated as the pixel moves between them. Sustained
// throughput is one pixel per cycle; result_stall reaches pixel_stall only when both registers
// are full. Pixels equal to the background color are not stored; every other pixel gets the
// next packed store address, wrapping at STORE_WORDS. Runs are reported when they close,
// column counts on the last pixel of a column. Write configuration only while idle.
module sprite_column_run_encoder #(
	parameter int MAX_FRAME_HEIGHT = 256,
	parameter int STORE_WORDS      = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [scre_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [scre_pkg::COLOR_W-1:0]  cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic [scre_pkg::COLOR_W-1:0]  pixel,
	input  logic                          sheet_start,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          store_valid,
	output logic [scre_pkg::ADDR_W-1:0]   store_address,
	output logic [scre_pkg::COLOR_W-1:0]  store_pixel,
	output logic                          run_done,
	output logic [scre_pkg::START_W-1:0]  run_start,
	output logic [scre_pkg::LENGTH_W-1:0] run_length,
	output logic [scre_pkg::ADDR_W-1:0]   run_address,
	output logic                          column_done,
	output logic [scre_pkg::COUNT_W-1:0]  column_run_count
);

	scre_pkg::cfg_t               cfg;
	scre_pkg::result_t            result;
	scre_pkg::result_t            result_q;
	logic                         valid_s1;
	logic [scre_pkg::COLOR_W-1:0] pixel_s1;
	logic                         sheet_start_s1;
	logic                         out_valid_q;
	logic                         advance;
	logic                         load_s1;

	assign cfg_ready   = 1'b1;
	assign advance     = valid_s1 && (!out_valid_q || !result_stall);
	assign pixel_stall = valid_s1 && !advance;
	assign load_s1     = pixel_valid && !pixel_stall;

	scre_cfg #(
		.MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	scre_run_tracker #(
		.MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT),
		.STORE_WORDS     (STORE_WORDS)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.pixel      (pixel_s1),
		.sheet_start(sheet_start_s1),
		.cfg        (cfg),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pixel_s1       <= pixel;
			sheet_start_s1 <= sheet_start;
		end
		if (advance) begin
			result_q <= result;
		end
	end

	assign result_valid     = out_valid_q;
	assign store_valid      = result_q.store_valid;
	assign store_address    = result_q.store_address;
	assign store_pixel      = result_q.store_pixel;
	assign run_done         = result_q.run_done;
	assign run_start        = result_q.run_start;
	assign run_length       = result_q.run_length;
	assign run_address      = result_q.run_address;
	assign column_done      = result_q.column_done;
	assign column_run_count = result_q.column_run_count;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_stall |=> out_valid_q && $stable(result_q))
		else $error("held result beat overwritten");
	a_beat_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced beat did not reach result register");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> valid_s1 && out_valid_q && result_stall)
		else $error("input stalled with room available");
`endif

endmodule

// ----- sv/scre_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers: background color and clamped column height.
// Depends on scre_pkg.
module scre_cfg #(
	parameter int MAX_FRAME_HEIGHT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [scre_pkg::INDEX_W-1:0]        cfg_index,
	input  logic [scre_pkg::COLOR_W-1:0]        cfg_data,
	output scre_pkg::cfg_t                      cfg
);

	localparam int HMAX  = (MAX_FRAME_HEIGHT > 511) ? 511 : MAX_FRAME_HEIGHT;
	localparam int HRST  = (HMAX < 64) ? HMAX : 64;

	logic [scre_pkg::COLOR_W-1:0]  background_q;
	logic [scre_pkg::HEIGHT_W-1:0] height_q;
	logic [scre_pkg::HEIGHT_W-1:0] height_raw;
	logic [scre_pkg::HEIGHT_W-1:0] height_eff;

	// clamp the written height to 1..min(MAX_FRAME_HEIGHT, 511)
	always_comb begin
		height_raw = cfg_data[scre_pkg::HEIGHT_W-1:0];
		height_eff = height_raw;
		if (height_raw == '0) begin
			height_eff = scre_pkg::HEIGHT_W'(1);
		end else if (height_raw > scre_pkg::HEIGHT_W'(HMAX)) begin
			height_eff = scre_pkg::HEIGHT_W'(HMAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q <= '0;
			height_q     <= scre_pkg::HEIGHT_W'(HRST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (scre_pkg::cfg_reg_t'(cfg_index))
				scre_pkg::CFG_BACKGROUND: background_q <= cfg_data;
				scre_pkg::CFG_HEIGHT:     height_q     <= height_eff;
				default: ;
			endcase
		end
	end

	assign cfg.background = background_q;
	assign cfg.height     = height_q;

endmodule

// ----- sv/scre_run_tracker.sv -----
`timescale 1ns / 1ps
// Run and column state with the per-pixel update and result logic.
// Depends on scre_pkg.
module scre_run_tracker #(
	parameter int MAX_FRAME_HEIGHT = 256,
	parameter int STORE_WORDS      = 1048576
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [scre_pkg::COLOR_W-1:0] pixel,
	input  logic                         sheet_start,
	input  scre_pkg::cfg_t               cfg,
	output scre_pkg::result_t            result
);

	localparam int RW  = $clog2(MAX_FRAME_HEIGHT);
	localparam int AW  = $clog2(STORE_WORDS);
	localparam int CW  = (RW + 1 > scre_pkg::HEIGHT_W) ? RW + 1 : scre_pkg::HEIGHT_W;
	localparam int RWX = (RW > scre_pkg::START_W) ? RW : scre_pkg::START_W;
	localparam int AWX = (AW > scre_pkg::ADDR_W) ? AW : scre_pkg::ADDR_W;

	logic                          in_run_q;
	logic [RW-1:0]                 row_q;
	logic [RW-1:0]                 begin_q;
	logic [scre_pkg::LENGTH_W-1:0] cnt_q;
	logic [AW-1:0]                 wp_q;
	logic [AW-1:0]                 base_q;
	logic [scre_pkg::COUNT_W-1:0]  runs_q;

	logic                          run_v;
	logic [RW-1:0]                 row_v;
	logic [scre_pkg::LENGTH_W-1:0] cnt_v;
	logic [AW-1:0]                 wp_v;
	logic [scre_pkg::COUNT_W-1:0]  runs_v;
	logic                          solid;
	logic                          last;
	logic                          close_now;
	logic                          in_run_n;
	logic [RW-1:0]                 row_n;
	logic [RW-1:0]                 begin_n;
	logic [scre_pkg::LENGTH_W-1:0] cnt_n;
	logic [AW-1:0]                 wp_n;
	logic [AW-1:0]                 base_n;
	logic [scre_pkg::COUNT_W-1:0]  runs_inc;
	logic [scre_pkg::COUNT_W-1:0]  runs_n;
	logic [RWX-1:0]                begin_x;
	logic [AWX-1:0]                wp_x;
	logic [AWX-1:0]                base_x;

	always_comb begin
		// sheet start clears the open run, position, pointer and counts before this pixel
		run_v  = in_run_q & ~sheet_start;
		row_v  = sheet_start ? '0 : row_q;
		cnt_v  = sheet_start ? '0 : cnt_q;
		wp_v   = sheet_start ? '0 : wp_q;
		runs_v = sheet_start ? '0 : runs_q;

		solid = (pixel != cfg.background);
		last  = (CW'(row_v) + CW'(1)) >= CW'(cfg.height);

		begin_n = begin_q;
		base_n  = base_q;
		cnt_n   = cnt_v;
		wp_n    = wp_v;
		if (solid) begin
			if (!run_v) begin
				begin_n = row_v;
				base_n  = wp_v;
				cnt_n   = '0;
			end
			wp_n = (wp_v == AW'(STORE_WORDS - 1)) ? '0 : wp_v + AW'(1);
			if (cnt_n != '1) begin
				cnt_n = cnt_n + scre_pkg::LENGTH_W'(1);
			end
		end

		close_now = (!solid && run_v) || (last && solid);
		in_run_n  = solid && !last;
		runs_inc  = runs_v;
		if (close_now && runs_v != '1) begin
			runs_inc = runs_v + scre_pkg::COUNT_W'(1);
		end
		runs_n = last ? '0 : runs_inc;
		row_n  = last ? '0 : row_v + RW'(1);

		begin_x = RWX'(begin_n);
		wp_x    = AWX'(wp_v);
		base_x  = AWX'(base_n);

		result                  = '0;
		result.store_valid      = solid;
		result.store_address    = solid ? wp_x[scre_pkg::ADDR_W-1:0] : '0;
		result.store_pixel      = solid ? pixel : '0;
		result.run_done         = close_now;
		result.run_start        = close_now ? begin_x[scre_pkg::START_W-1:0] : '0;
		result.run_length       = close_now ? cnt_n : '0;
		result.run_address      = close_now ? base_x[scre_pkg::ADDR_W-1:0] : '0;
		result.column_done      = last;
		result.column_run_count = last ? runs_inc : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			row_q    <= '0;
			begin_q  <= '0;
			cnt_q    <= '0;
			wp_q     <= '0;
			base_q   <= '0;
			runs_q   <= '0;
		end else if (advance) begin
			in_run_q <= in_run_n;
			row_q    <= row_n;
			begin_q  <= begin_n;
			cnt_q    <= cnt_n;
			wp_q     <= wp_n;
			base_q   <= base_n;
			runs_q   <= runs_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_close_solid_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.run_done && result.store_valid |-> result.column_done)
		else $error("solid pixel closed a run before column end");
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.run_done |-> result.run_length != '0)
		else $error("empty run reported");
	a_column_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.column_done |=> row_q == '0 && runs_q == '0 && !in_run_q)
		else $error("column end did not rewind state");
	a_open_after_store: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.store_valid && !result.column_done |=> in_run_q && cnt_q != '0)
		else $error("stored pixel left no open run");
`endif

endmodule

// ----- dv/scre_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the sprite column run encoder: tracks the configuration writes and the
// accepted pixel beats, predicts each result beat and compares it field by field.
// Depends on scre_pkg for the register indexes and the result layout.
module scre_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [scre_pkg::INDEX_W-1:0] cfg_index,
	input  logic [scre_pkg::COLOR_W-1:0] cfg_data,
	input  logic                         pixel_valid,
	input  logic                         pixel_stall,
	input  logic [scre_pkg::COLOR_W-1:0] pixel,
	input  logic                         sheet_start,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  scre_pkg::result_t            observed,
	output int                           error_count,
	output int                           pending
);

	localparam int MAX_HEIGHT = 256;

	logic [scre_pkg::COLOR_W-1:0]  background = '0;
	logic [scre_pkg::HEIGHT_W-1:0] height     = 9'd64;

	logic                          open_run   = 1'b0;
	logic [scre_pkg::START_W-1:0]  row        = '0;
	logic [scre_pkg::START_W-1:0]  run_row    = '0;
	logic [scre_pkg::LENGTH_W-1:0] run_pixels = '0;
	logic [scre_pkg::ADDR_W-1:0]   write_ptr  = '0;
	logic [scre_pkg::ADDR_W-1:0]   run_base   = '0;
	logic [scre_pkg::COUNT_W-1:0]  col_runs   = '0;

	scre_pkg::result_t expected_results[$];
	scre_pkg::result_t want;

	function automatic scre_pkg::result_t close_run(input scre_pkg::result_t r);
		scre_pkg::result_t c;
		c            = r;
		c.run_done   = 1'b1;
		c.run_start  = run_row;
		c.run_length = run_pixels;
		c.run_address = run_base;
		open_run     = 1'b0;
		if (col_runs != 8'hFF)
			col_runs = col_runs + 1'b1;
		return c;
	endfunction

	function automatic scre_pkg::result_t encode_pixel(input logic [scre_pkg::COLOR_W-1:0] px,
			input logic restart);
		scre_pkg::result_t r;
		int                h;
		r = '0;
		h = height;
		if (h == 0)
			h = 1;
		if (h > MAX_HEIGHT)
			h = MAX_HEIGHT;
		if (restart) begin
			write_ptr  = '0;
			row        = '0;
			open_run   = 1'b0;
			run_pixels = '0;
			col_runs   = '0;
		end
		if (px != background) begin
			if (!open_run) begin
				open_run   = 1'b1;
				run_row    = row;
				run_base   = write_ptr;
				run_pixels = '0;
			end
			r.store_valid   = 1'b1;
			r.store_address = write_ptr;
			r.store_pixel   = px;
			write_ptr       = write_ptr + 1'b1;
			if (run_pixels != 9'h1FF)
				run_pixels = run_pixels + 1'b1;
		end else if (open_run) begin
			r = close_run(r);
		end
		if (int'(row) + 1 >= h) begin
			if (open_run)
				r = close_run(r);
			r.column_done      = 1'b1;
			r.column_run_count = col_runs;
			col_runs           = '0;
			row                = '0;
		end else begin
			row = row + 1'b1;
		end
		return r;
	endfunction

	function automatic int field_mismatch(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	function automatic int beat_mismatches(input scre_pkg::result_t e,
			input scre_pkg::result_t a);
		int n;
		n = 0;
		n += field_mismatch("store_valid", e.store_valid, a.store_valid);
		n += field_mismatch("store_address", e.store_address, a.store_address);
		n += field_mismatch("store_pixel", e.store_pixel, a.store_pixel);
		n += field_mismatch("run_done", e.run_done, a.run_done);
		n += field_mismatch("run_start", e.run_start, a.run_start);
		n += field_mismatch("run_length", e.run_length, a.run_length);
		n += field_mismatch("run_address", e.run_address, a.run_address);
		n += field_mismatch("column_done", e.column_done, a.column_done);
		n += field_mismatch("column_run_count", e.column_run_count, a.column_run_count);
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background = '0;
			height     = 9'd64;
			open_run   = 1'b0;
			row        = '0;
			run_row    = '0;
			run_pixels = '0;
			write_ptr  = '0;
			run_base   = '0;
			col_runs   = '0;
			expected_results.delete();
			pending     = 0;
			error_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == scre_pkg::CFG_BACKGROUND)
					background = cfg_data;
				else if (cfg_index == scre_pkg::CFG_HEIGHT)
					height = cfg_data[scre_pkg::HEIGHT_W-1:0];
			end
			if (pixel_valid && !pixel_stall)
				expected_results.insert(expected_results.size(),
					encode_pixel(pixel, sheet_start));
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h", $time, observed);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (beat_mismatches(want, observed) != 0)
						error_count++;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- dv/sprite_column_run_encoder_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the sprite column run encoder: directed columns, then random phases
// under varying sender idling and receiver stalls. Depends on scre_pkg, scre_checker and the RTL.
module sprite_column_run_encoder_test;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [scre_pkg::INDEX_W-1:0]    cfg_index = '0;
	logic [scre_pkg::COLOR_W-1:0]    cfg_data = '0;
	logic                            pixel_valid = 1'b0;
	logic                            pixel_stall;
	logic [scre_pkg::COLOR_W-1:0]    pixel = '0;
	logic                            sheet_start = 1'b0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic                            store_valid;
	logic [scre_pkg::ADDR_W-1:0]     store_address;
	logic [scre_pkg::COLOR_W-1:0]    store_pixel;
	logic                            run_done;
	logic [scre_pkg::START_W-1:0]    run_start;
	logic [scre_pkg::LENGTH_W-1:0]   run_length;
	logic [scre_pkg::ADDR_W-1:0]     run_address;
	logic                            column_done;
	logic [scre_pkg::COUNT_W-1:0]    column_run_count;

	scre_pkg::result_t               observed;
	int                              error_count;
	int                              pending;
	int                              idle_pct = 0;
	int                              stall_pct = 0;
	logic [scre_pkg::COLOR_W-1:0]    background = '0;

	sprite_column_run_encoder uut (.*);

	assign observed = {store_valid, store_address, store_pixel, run_done, run_start, run_length,
		run_address, column_done, column_run_count};

	scre_checker encoder_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.sheet_start  (sheet_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.observed     (observed),
		.error_count  (error_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#2ms;
		$display("[sprite_column_run_encoder] ERROR");
		$finish;
	end

	task automatic write_cfg(input scre_pkg::cfg_reg_t index,
			input logic [scre_pkg::COLOR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [scre_pkg::COLOR_W-1:0] bg,
			input logic [scre_pkg::HEIGHT_W-1:0] h);
		background = bg;
		write_cfg(scre_pkg::CFG_BACKGROUND, bg);
		write_cfg(scre_pkg::CFG_HEIGHT, {7'($urandom_range(127)), h});
	endtask

	task automatic send_pixel(input logic [scre_pkg::COLOR_W-1:0] px, input logic restart);
		while ($urandom_range(99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= px;
		sheet_start <= restart;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results;
		pixel_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [scre_pkg::COLOR_W-1:0] random_pixel;
		case ($urandom_range(9))
			0, 1, 2, 3: return background;
			4:          return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default:    return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic run_phase(input int items, input int idle, input int stall,
			input logic [scre_pkg::COLOR_W-1:0] bg, input logic [scre_pkg::HEIGHT_W-1:0] h,
			input bit restarts);
		set_config(bg, h);
		idle_pct  = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++)
			send_pixel(random_pixel(), restarts && ($urandom_range(63) == 0));
		drain_results();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_config(16'h0000, 9'd4);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'h8000, 1'b0);
		repeat (4) send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		drain_results();

		write_cfg(scre_pkg::CFG_HEIGHT, 16'd2);
		send_pixel(16'h1234, 1'b0);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'hAAAA, 1'b1);
		send_pixel(16'h0000, 1'b0);
		drain_results();

		write_cfg(scre_pkg::CFG_HEIGHT, 16'd0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h7FFF, 1'b0);
		drain_results();

		set_config(16'hFFFF, 9'd3);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0000, 1'b0);
		drain_results();

		run_phase(160, 0, 0, 16'($urandom_range(16'hFFFF)), 9'($urandom_range(1, 8)), 1'b1);
		run_phase(240, 65, 0, 16'h0000, 9'd511, 1'b0);
		run_phase(160, 0, 65, 16'($urandom_range(16'hFFFF)), 9'($urandom_range(2, 24)), 1'b1);
		run_phase(120, 11, 11, 16'($urandom_range(16'hFFFF)), 9'd256, 1'b0);
		run_phase(100, 0, 0, 16'($urandom_range(16'hFFFF)), 9'($urandom_range(1, 300)), 1'b1);

		if (error_count == 0)
			$display("[sprite_column_run_encoder] OK");
		else
			$display("[sprite_column_run_encoder] ERROR");
		$finish;
	end

endmodule
